### hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define LFE_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define LFE_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/lfe_pkg.sv
// Types, constants and arithmetic helpers of the light flicker effect engine.
`default_nettype none

package lfe_pkg;

	localparam int COLOR_FRAC_BITS = 12;
	localparam int TIME_FRAC_BITS  = 12;

	localparam int LEVEL_W = 13;
	localparam int TIME_W  = 12;
	localparam int RAND_W  = 16;
	localparam int COUNT_W = 14;
	localparam int STEP_W  = 14;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int NUM_CH  = 3;

	// Fixed-point constants, rounded to the nearest code.
	localparam int ONE_C        = 1 << COLOR_FRAC_BITS;
	localparam int C_HALF       = ((1 << COLOR_FRAC_BITS) + 1) / 2;
	localparam int C_GREEN_MIN  = ((6 << COLOR_FRAC_BITS) + 5) / 10;
	localparam int C_GREEN_SPAN = ((4 << COLOR_FRAC_BITS) + 5) / 10;
	localparam int C_JIT_MIN    = ((1 << COLOR_FRAC_BITS) + 5) / 10;
	localparam int C_JIT_SPAN   = ((2 << COLOR_FRAC_BITS) + 5) / 10;
	localparam int T_FLICK_MIN  = ((5 << TIME_FRAC_BITS) + 50) / 100;
	localparam int T_FLICK_SPAN = ((2 << TIME_FRAC_BITS) + 5) / 10;
	localparam int T_SLOW_MIN   = ((2 << TIME_FRAC_BITS) + 5) / 10;
	localparam int T_SLOW_SPAN  = ((3 << TIME_FRAC_BITS) + 5) / 10;
	localparam int T_ERR_SPAN   = ((1 << TIME_FRAC_BITS) + 5) / 10;
	localparam int T_QUARTER    = ((1 << TIME_FRAC_BITS) + 2) / 4;

	localparam logic [LEVEL_W-1:0] ONE_LEVEL = LEVEL_W'(ONE_C);

	typedef enum logic [1:0] {
		MODE_FLICKER  = 2'd0,
		MODE_SLOW     = 2'd1,
		MODE_ERRATIC  = 2'd2,
		MODE_CAULDRON = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE       = 2'd0,
		REG_BASE_RED   = 2'd1,
		REG_BASE_GREEN = 2'd2,
		REG_BASE_BLUE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] elapsed;
		logic [RAND_W-1:0] rand_period;
		logic [RAND_W-1:0] rand_red;
		logic [RAND_W-1:0] rand_green;
		logic [RAND_W-1:0] rand_blue;
	} tick_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] out_red;
		logic [LEVEL_W-1:0] out_green;
		logic [LEVEL_W-1:0] out_blue;
		logic               color_updated;
	} result_t;

	typedef struct packed {
		mode_t                           mode;
		logic [NUM_CH-1:0][LEVEL_W-1:0] base;
	} cfg_t;

	// Floor of k * r / 65536.
	function automatic logic [LEVEL_W-1:0] rand_scale(input logic [LEVEL_W-1:0] k,
			input logic [RAND_W-1:0] r);
		logic [LEVEL_W+RAND_W-1:0] p;
		p = (LEVEL_W+RAND_W)'(k) * (LEVEL_W+RAND_W)'(r);
		return p[LEVEL_W+RAND_W-1:RAND_W];
	endfunction

	function automatic logic [LEVEL_W-1:0] clamp_unit(input logic signed [LEVEL_W:0] v);
		logic [LEVEL_W-1:0] res;
		if (v[LEVEL_W])
			res = '0;
		else if (v[LEVEL_W-1:0] > ONE_LEVEL)
			res = ONE_LEVEL;
		else
			res = v[LEVEL_W-1:0];
		return res;
	endfunction

	// Move cur toward tgt by amt; land on tgt rather than pass it.
	function automatic logic [LEVEL_W-1:0] slew(input logic [LEVEL_W-1:0] cur,
			input logic [LEVEL_W-1:0] tgt, input logic [STEP_W-1:0] amt);
		logic [LEVEL_W-1:0] gap;
		logic [LEVEL_W-1:0] res;
		gap = '0;
		res = cur;
		if (cur > tgt) begin
			gap = cur - tgt;
			if (STEP_W'(gap) <= amt)
				res = tgt;
			else
				res = cur - amt[LEVEL_W-1:0];
		end else if (cur < tgt) begin
			gap = tgt - cur;
			if (STEP_W'(gap) <= amt)
				res = tgt;
			else
				res = cur + amt[LEVEL_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/lfe_cfg_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module lfe_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lfe_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [lfe_pkg::DATA_W-1:0]   pwdata,
	output logic      [lfe_pkg::DATA_W-1:0]   prdata,
	output lfe_pkg::cfg_t                     cfg
);

	lfe_pkg::cfg_t     cfg_q;
	lfe_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx   = lfe_pkg::reg_idx_t'(paddr[lfe_pkg::ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= lfe_pkg::MODE_FLICKER;
			cfg_q.base <= {lfe_pkg::NUM_CH{lfe_pkg::ONE_LEVEL}};
		end else if (wr_en) begin
			case (idx)
				lfe_pkg::REG_MODE:       cfg_q.mode    <= lfe_pkg::mode_t'(pwdata[1:0]);
				lfe_pkg::REG_BASE_RED:   cfg_q.base[0] <= pwdata[lfe_pkg::LEVEL_W-1:0];
				lfe_pkg::REG_BASE_GREEN: cfg_q.base[1] <= pwdata[lfe_pkg::LEVEL_W-1:0];
				lfe_pkg::REG_BASE_BLUE:  cfg_q.base[2] <= pwdata[lfe_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			lfe_pkg::REG_MODE:       prdata = lfe_pkg::DATA_W'(cfg_q.mode);
			lfe_pkg::REG_BASE_RED:   prdata = lfe_pkg::DATA_W'(cfg_q.base[0]);
			lfe_pkg::REG_BASE_GREEN: prdata = lfe_pkg::DATA_W'(cfg_q.base[1]);
			lfe_pkg::REG_BASE_BLUE:  prdata = lfe_pkg::DATA_W'(cfg_q.base[2]);
			default:                 prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/lfe_datapath.sv
// Effect state (countdown, levels, targets) and the per-request update logic.
`default_nettype none

module lfe_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire lfe_pkg::tick_t  tick,
	input  wire lfe_pkg::cfg_t   cfg,
	output lfe_pkg::result_t     result_n
);

	localparam int LW = lfe_pkg::LEVEL_W;
	localparam int CW = lfe_pkg::COUNT_W;
	localparam int SW = lfe_pkg::STEP_W;
	localparam int NC = lfe_pkg::NUM_CH;

	logic signed [CW-1:0]   countdown_q;
	logic        [LW-1:0]   level_q  [NC];
	logic        [LW-1:0]   target_q [NC];

	logic signed [CW-1:0]   dec;
	logic                   expired;
	logic signed [CW-1:0]   countdown_n;
	logic        [LW-1:0]   level_n  [NC];
	logic        [LW-1:0]   target_n [NC];
	logic        [LW-1:0]   tgt_new  [NC];
	logic        [LW-1:0]   tgt_use  [NC];
	logic        [LW-1:0]   flick    [NC];
	logic        [lfe_pkg::RAND_W-1:0] jit_rand [NC];
	logic        [SW-1:0]   step_raw;
	logic        [SW-1:0]   amt;
	logic        [LW-1:0]   min_t;
	logic        [LW-1:0]   span_t;
	logic signed [CW-1:0]   reload;
	logic                   updated;

	assign dec     = countdown_q - $signed(CW'(tick.elapsed));
	assign expired = dec[CW-1] || (dec == '0);

	// Slew step: 3 * elapsed, moved from time to colour format.
	assign step_raw = SW'(tick.elapsed) + SW'({tick.elapsed, 1'b0});
	assign amt = (lfe_pkg::COLOR_FRAC_BITS >= lfe_pkg::TIME_FRAC_BITS)
		? step_raw << (lfe_pkg::COLOR_FRAC_BITS - lfe_pkg::TIME_FRAC_BITS)
		: step_raw >> (lfe_pkg::TIME_FRAC_BITS - lfe_pkg::COLOR_FRAC_BITS);

	assign tgt_new[0] = lfe_pkg::rand_scale(LW'(lfe_pkg::C_HALF), tick.rand_period);
	assign tgt_new[1] = LW'(lfe_pkg::C_GREEN_MIN)
		+ lfe_pkg::rand_scale(LW'(lfe_pkg::C_GREEN_SPAN), tick.rand_red);
	assign tgt_new[2] = lfe_pkg::rand_scale(LW'(lfe_pkg::C_HALF), tick.rand_green);

	assign jit_rand[0] = tick.rand_red;
	assign jit_rand[1] = tick.rand_green;
	assign jit_rand[2] = tick.rand_blue;

	always_comb begin
		case (cfg.mode)
			lfe_pkg::MODE_FLICKER: begin
				min_t  = LW'(lfe_pkg::T_FLICK_MIN);
				span_t = LW'(lfe_pkg::T_FLICK_SPAN);
			end
			lfe_pkg::MODE_SLOW: begin
				min_t  = LW'(lfe_pkg::T_SLOW_MIN);
				span_t = LW'(lfe_pkg::T_SLOW_SPAN);
			end
			default: begin
				min_t  = '0;
				span_t = LW'(lfe_pkg::T_ERR_SPAN);
			end
		endcase
	end

	assign reload = $signed(CW'(min_t + lfe_pkg::rand_scale(span_t, tick.rand_period)));

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			flick[i] = lfe_pkg::clamp_unit($signed({1'b0, cfg.base[i]})
				- $signed((LW+1)'(LW'(lfe_pkg::C_JIT_MIN)
				+ lfe_pkg::rand_scale(LW'(lfe_pkg::C_JIT_SPAN), jit_rand[i]))));
			tgt_use[i] = expired ? tgt_new[i] : target_q[i];
		end
	end

	always_comb begin
		target_n = target_q;
		if (cfg.mode == lfe_pkg::MODE_CAULDRON) begin
			countdown_n = expired ? $signed(CW'(lfe_pkg::T_QUARTER)) : dec;
			target_n    = tgt_use;
			for (int i = 0; i < NC; i++)
				level_n[i] = lfe_pkg::slew(level_q[i], tgt_use[i], amt);
			updated = 1'b1;
		end else begin
			countdown_n = expired ? reload : dec;
			for (int i = 0; i < NC; i++)
				level_n[i] = expired ? flick[i] : level_q[i];
			updated     = expired;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= '0;
			for (int i = 0; i < NC; i++) begin
				level_q[i]  <= '0;
				target_q[i] <= '0;
			end
		end else if (advance) begin
			countdown_q <= countdown_n;
			level_q     <= level_n;
			target_q    <= target_n;
		end
	end

	assign result_n.out_red       = level_n[0];
	assign result_n.out_green     = level_n[1];
	assign result_n.out_blue      = level_n[2];
	assign result_n.color_updated = updated;

endmodule

`default_nettype wire

### hw/rtl/light_flicker_effect_engine.sv
// Top level of the light flicker effect engine: request and result registers.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  tick      | tick_valid / tick_ready    | tick_t: elapsed, four random words
//  result    | result_valid / result_ready| result_t: three levels, updated flag
//  config    | psel/penable/pwrite/pready | paddr, pwdata, prdata (4 registers)
//
// One request per cycle while the output register is free or draining; a request
// waits in the input register, and its result is registered in the output register.
// The countdown, levels and targets update from the input register as it advances.
// A stalled result holds the output register; the input register still drains into
// it as soon as the result is taken, so tick_ready stays high while results flow.
// Reset clears the state to zero, mode to flicker, base levels to 1.0.
`default_nettype none

module light_flicker_effect_engine (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         tick_valid,
	output logic                              tick_ready,
	input  wire lfe_pkg::tick_t               tick,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output lfe_pkg::result_t                  result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lfe_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [lfe_pkg::DATA_W-1:0]   pwdata,
	output logic      [lfe_pkg::DATA_W-1:0]   prdata,
	output logic                              pready
);

	lfe_pkg::cfg_t    cfg;
	lfe_pkg::tick_t   tick_s1;
	logic             valid_s1;
	lfe_pkg::result_t result_n;
	lfe_pkg::result_t result_q;
	logic             result_valid_q;
	logic             advance;

	assign pready = 1'b1;

	lfe_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	lfe_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.tick     (tick_s1),
		.cfg      (cfg),
		.result_n (result_n)
	);

	// Advance the held request once the output register is free or draining.
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign tick_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (tick_ready)
				valid_s1 <= tick_valid;
			if (advance)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready)
			tick_s1 <= tick;
		if (advance)
			result_q <= result_n;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

### hw/rtl/lfe_checker.sv
// Port-level checker for the light flicker effect engine, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module lfe_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             tick_ready,
	input wire logic             result_valid,
	input wire logic             result_ready,
	input wire lfe_pkg::result_t result,
	input wire logic             pready
);

	`LFE_ASSERT(a_result_hold, clk, arst_n, result_valid && !result_ready |=> result_valid && $stable(result), "stalled result changed")
	`LFE_ASSERT(a_ready_when_empty, clk, arst_n, !result_valid |-> tick_ready, "tick_ready low with empty output")
	`LFE_ASSERT(a_level_range, clk, arst_n, result_valid |-> (result.out_red <= lfe_pkg::ONE_LEVEL) && (result.out_green <= lfe_pkg::ONE_LEVEL) && (result.out_blue <= lfe_pkg::ONE_LEVEL), "level above 1.0")
	`LFE_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")

endmodule

bind light_flicker_effect_engine lfe_checker u_lfe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_ready   (tick_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.pready       (pready)
);

`default_nettype wire
